### rtl/wia_pkg.sv
// Package for the multiword integer ALU.
// Holds the transfer payload types, the command codes and the arithmetic unit controls.
// No dependencies.
`default_nettype none

package wia_pkg;

   localparam int WORD_COUNT_DEF = 8;
   localparam int WORD_WIDTH_DEF = 32;
   localparam int FIELD_W        = 32;
   localparam int CMD_W          = 3;

   localparam logic [CMD_W-1:0] CMD_COPY = 3'd0;
   localparam logic [CMD_W-1:0] CMD_NOT  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INC  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEC  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_NEG  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd6;
   localparam logic [CMD_W-1:0] CMD_MUL  = 3'd7;

   localparam int ACC_OP_W = 3;
   localparam logic [ACC_OP_W-1:0] ACC_HOLD      = 3'd0;
   localparam logic [ACC_OP_W-1:0] ACC_INIT      = 3'd1;
   localparam logic [ACC_OP_W-1:0] ACC_ADD_WORDS = 3'd2;
   localparam logic [ACC_OP_W-1:0] ACC_ADD_PROD  = 3'd3;
   localparam logic [ACC_OP_W-1:0] ACC_SHIFT     = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [FIELD_W-1:0] a_word;
      logic [FIELD_W-1:0] b_word;
      logic               last_word;
   } req_type;

   typedef struct packed {
      logic [FIELD_W-1:0] result_word;
      logic               last_result;
   } rsp_type;

   typedef struct packed {
      logic                load_prod;
      logic [ACC_OP_W-1:0] acc_op;
   } arith_ctrl_type;

endpackage

`default_nettype wire

### rtl/wia_operand_store.sv
// Operand stores for A and B with a fill count; unfilled words read as zero.
// Depends on wia_pkg for the default parameter values.
`default_nettype none

module wia_operand_store #(
   parameter int WORD_COUNT = wia_pkg::WORD_COUNT_DEF,
   parameter int WORD_WIDTH = wia_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [WORD_WIDTH-1:0]         wr_a,
   input  wire logic [WORD_WIDTH-1:0]         wr_b,
   input  wire logic                          clear,
   input  wire logic [$clog2(WORD_COUNT)-1:0] rd_a_idx,
   input  wire logic [$clog2(WORD_COUNT)-1:0] rd_b_idx,
   output logic      [WORD_WIDTH-1:0]         rd_a,
   output logic      [WORD_WIDTH-1:0]         rd_b
);

   localparam int IDX_W = $clog2(WORD_COUNT);
   localparam int CNT_W = IDX_W + 1;

   logic [WORD_WIDTH-1:0] a_ff [WORD_COUNT];
   logic [WORD_WIDTH-1:0] b_ff [WORD_COUNT];
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  full;
   logic                  do_write;

   assign full     = (count_ff == CNT_W'(WORD_COUNT));
   assign do_write = wr_en && !full;

   always_comb begin
      count_in = count_ff;
      if (clear) begin
         count_in = '0;
      end else if (do_write) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         a_ff[count_ff[IDX_W-1:0]] <= wr_a;
         b_ff[count_ff[IDX_W-1:0]] <= wr_b;
      end
   end

   assign rd_a = ({1'b0, rd_a_idx} < count_ff) ? a_ff[rd_a_idx] : '0;
   assign rd_b = ({1'b0, rd_b_idx} < count_ff) ? b_ff[rd_b_idx] : '0;

endmodule

`default_nettype wire

### rtl/wia_arith_unit.sv
// Shared arithmetic unit: one word multiplier with a registered product and a wide accumulator.
// Depends on wia_pkg for the control struct and the accumulator operation codes.
`default_nettype none

module wia_arith_unit #(
   parameter int WORD_COUNT = wia_pkg::WORD_COUNT_DEF,
   parameter int WORD_WIDTH = wia_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                    clock,
   input  wire wia_pkg::arith_ctrl_type ctrl,
   input  wire logic                    init_carry,
   input  wire logic [WORD_WIDTH-1:0]   op_x,
   input  wire logic [WORD_WIDTH-1:0]   op_y,
   output logic      [WORD_WIDTH-1:0]   acc_word
);

   localparam int PROD_W = 2 * WORD_WIDTH;
   localparam int ACC_W  = PROD_W + $clog2(WORD_COUNT) + 1;

   logic [PROD_W-1:0] prod_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [ACC_W-1:0]  acc_in;

   always_ff @(posedge clock) begin
      if (ctrl.load_prod) begin
         prod_ff <= PROD_W'(op_x) * PROD_W'(op_y);
      end
   end

   always_comb begin
      case (ctrl.acc_op)
         wia_pkg::ACC_INIT:      acc_in = ACC_W'(init_carry);
         wia_pkg::ACC_ADD_WORDS: acc_in = acc_ff + ACC_W'(op_x) + ACC_W'(op_y);
         wia_pkg::ACC_ADD_PROD:  acc_in = acc_ff + ACC_W'(prod_ff);
         wia_pkg::ACC_SHIFT:     acc_in = acc_ff >> WORD_WIDTH;
         default:                acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc_word = acc_ff[WORD_WIDTH-1:0];

endmodule

`default_nettype wire

### rtl/wide_integer_alu_256_top.sv
// Top level of the multiword integer ALU: sequencer, operand stores and shared arithmetic unit.
// Depends on wia_pkg, wia_operand_store and wia_arith_unit.
//
// Operands arrive on the req_ channel, one word of A and one of B per transfer, least
// significant first. Words beyond WORD_COUNT are dropped and missing high words count
// as zero. The transfer with last_word set also carries the command and starts the
// operation; no other transfer produces a result.
// The rsp_ channel then delivers WORD_COUNT result words, least significant first, with
// last_result set on the most significant word. The result is taken modulo
// 2^(WORD_COUNT*WORD_WIDTH).
// Operand transfers are taken one per cycle while idle. After the last word, req_ready stays
// low while the sequencer drives the single accumulator: the add family runs an add step
// and an emit step per result word, and the multiply walks the product columns with one
// multiplier, loading and then adding each partial product before it emits the column's word.
// Results leave through an output register, so a stalled receiver holds the sequencer
// at the next result word without losing anything.
// Synchronous reset empties the operand stores and drops any operation in progress.
`default_nettype none

module wide_integer_alu_256_top #(
   parameter int WORD_COUNT = wia_pkg::WORD_COUNT_DEF,
   parameter int WORD_WIDTH = wia_pkg::WORD_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire wia_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output wia_pkg::rsp_type      rsp_payload
);

   localparam int IDX_W = $clog2(WORD_COUNT);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ADD_STEP = 3'd1;
   localparam logic [2:0] ST_MUL_PROD = 3'd2;
   localparam logic [2:0] ST_MUL_ADD  = 3'd3;
   localparam logic [2:0] ST_EMIT     = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [wia_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [IDX_W-1:0]            k_ff, k_in;
   logic [IDX_W-1:0]            i_ff, i_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   wia_pkg::rsp_type            rsp_payload_ff;

   logic                        req_fire;
   logic                        out_free;
   logic                        emit_load;
   logic                        store_clear;
   logic                        init_carry;
   logic [IDX_W-1:0]            rd_a_idx, rd_b_idx;
   logic [WORD_WIDTH-1:0]       rd_a, rd_b;
   logic [WORD_WIDTH-1:0]       op_x, op_y;
   logic [WORD_WIDTH-1:0]       acc_word;
   wia_pkg::arith_ctrl_type     ctrl;
   logic                        last_col;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_col  = (k_ff == IDX_W'(WORD_COUNT - 1));

   wia_operand_store #(
      .WORD_COUNT (WORD_COUNT),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_fire),
      .wr_a     (req_payload.a_word[WORD_WIDTH-1:0]),
      .wr_b     (req_payload.b_word[WORD_WIDTH-1:0]),
      .clear    (store_clear),
      .rd_a_idx (rd_a_idx),
      .rd_b_idx (rd_b_idx),
      .rd_a     (rd_a),
      .rd_b     (rd_b)
   );

   wia_arith_unit #(
      .WORD_COUNT (WORD_COUNT),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_arith (
      .clock      (clock),
      .ctrl       (ctrl),
      .init_carry (init_carry),
      .op_x       (op_x),
      .op_y       (op_y),
      .acc_word   (acc_word)
   );

   always_comb begin
      rd_a_idx = (state_ff == ST_ADD_STEP) ? k_ff : i_ff;
      rd_b_idx = (state_ff == ST_ADD_STEP) ? k_ff : k_ff - i_ff;
   end

   always_comb begin
      op_x = rd_a;
      op_y = rd_b;
      if (state_ff == ST_ADD_STEP) begin
         if (cmd_ff inside {wia_pkg::CMD_NOT, wia_pkg::CMD_NEG}) begin
            op_x = ~rd_a;
         end
         case (cmd_ff)
            wia_pkg::CMD_ADD: op_y = rd_b;
            wia_pkg::CMD_SUB: op_y = ~rd_b;
            wia_pkg::CMD_DEC: op_y = '1;
            default:          op_y = '0;
         endcase
      end
   end

   assign init_carry = req_payload.command inside
                       {wia_pkg::CMD_INC, wia_pkg::CMD_NEG, wia_pkg::CMD_SUB};

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      emit_load   = 1'b0;
      store_clear = 1'b0;
      ctrl        = '{load_prod: 1'b0, acc_op: wia_pkg::ACC_HOLD};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && req_payload.last_word) begin
               cmd_in      = req_payload.command;
               k_in        = '0;
               i_in        = '0;
               ctrl.acc_op = wia_pkg::ACC_INIT;
               state_in    = (req_payload.command == wia_pkg::CMD_MUL) ?
                             ST_MUL_PROD : ST_ADD_STEP;
            end
         end
         ST_ADD_STEP: begin
            ctrl.acc_op = wia_pkg::ACC_ADD_WORDS;
            state_in    = ST_EMIT;
         end
         ST_MUL_PROD: begin
            ctrl.load_prod = 1'b1;
            state_in       = ST_MUL_ADD;
         end
         ST_MUL_ADD: begin
            ctrl.acc_op = wia_pkg::ACC_ADD_PROD;
            if (i_ff == k_ff) begin
               state_in = ST_EMIT;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = ST_MUL_PROD;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               emit_load   = 1'b1;
               ctrl.acc_op = wia_pkg::ACC_SHIFT;
               i_in        = '0;
               if (last_col) begin
                  store_clear = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = (cmd_ff == wia_pkg::CMD_MUL) ? ST_MUL_PROD : ST_ADD_STEP;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cmd_ff       <= wia_pkg::CMD_COPY;
         k_ff         <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cmd_ff       <= cmd_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_payload_ff.result_word <= wia_pkg::FIELD_W'(acc_word);
         rsp_payload_ff.last_result <= last_col;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### rtl/wia_checker.sv
// Port-level checker for the multiword integer ALU, with its bind to the top level.
// Depends on wia_pkg and wide_integer_alu_256_top.
`default_nettype none

module wia_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire wia_pkg::req_type req_payload,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire wia_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("Result transfer changed while stalled.");

   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.last_word |=> !req_ready)
      else $error("Input taken straight after the last operand word.");

   a_busy_mid_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_result |-> !req_ready)
      else $error("Input ready while result words are still pending.");

   a_busy_after_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_payload.last_result |=>
         !req_ready || (rsp_valid && rsp_payload.last_result))
      else $error("Input ready before the final result word was sent.");

endmodule

bind wide_integer_alu_256_top wia_checker u_wia_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
